FILE: src/crd_pkg.sv
// Package for the camera ray direction block: widths, register indexes,
// lane helper and the sideband structs passed between pipeline sections.
// No dependencies.
`default_nettype none

package crd_pkg;

    // configuration port
    localparam int REG_W     = 48;
    localparam int NUM_REGS  = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CORNER_ORIGIN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_ALONG_U = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CORNER_ALONG_V = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_EYE_POSITION   = 2'd3;

    // screen coordinates, unsigned Q1.15
    localparam int               COORD_W    = 16;
    localparam int               COORD_FRAC = 15;
    localparam logic [COORD_W-1:0] COORD_ONE = 16'd32768;

    // vector lanes, signed Q8.8, x in the low lane
    localparam int LANE_W  = 16;
    localparam int DELTA_W = LANE_W + 1;
    localparam int PROD_W  = 2 * DELTA_W;
    localparam int D_W     = 36;
    localparam int MAG_W   = 34;
    localparam int POS_W   = 6;

    // the largest normalised magnitude lies in [2^29, 2^30)
    localparam int NORM_W   = 30;
    localparam int NORM_TOP = NORM_W - 1;
    localparam int SQ_W     = 2 * NORM_W;
    localparam int SUM_W    = SQ_W + 2;

    // integer square root, one result bit per stage
    localparam int SQRT_STEPS = SUM_W / 2;
    localparam int SQRT_RES_W = SUM_W + 1;
    localparam int ROOT_W     = SQRT_STEPS;

    // division, one quotient bit per stage
    localparam int DIR_FRAC_BITS = 14;
    localparam int QUOT_W        = DIR_FRAC_BITS + 1;
    localparam int NUM_W         = NORM_W + DIR_FRAC_BITS + 1;
    localparam int DIV_W         = ROOT_W + QUOT_W;

    localparam int OUT_W      = 16;
    localparam int OUT_CALC_W = 32;

    typedef struct packed {
        logic [2:0]             neg;
        logic                   zero;
        logic [2:0][NORM_W-1:0] mag;
    } crd_side_t;

    typedef struct packed {
        logic [2:0] neg;
        logic       zero;
    } crd_dside_t;

    function automatic logic signed [LANE_W-1:0] lane_of(input logic [REG_W-1:0] r,
                                                         input int k);
        return r[LANE_W*k +: LANE_W];
    endfunction

endpackage

`default_nettype wire

FILE: src/crd_in_if.sv
// Request channel carrying screen coordinates into the ray block.
// Depends on crd_pkg.
`default_nettype none

interface crd_in_if;
    import crd_pkg::*;

    logic               valid;
    logic               ready;
    logic [COORD_W-1:0] screen_u;
    logic [COORD_W-1:0] screen_v;

    modport source (output valid, output screen_u, output screen_v, input ready);
    modport sink   (input valid, input screen_u, input screen_v, output ready);
endinterface

`default_nettype wire

FILE: src/crd_out_if.sv
// Request channel carrying unit ray directions out of the ray block.
// Depends on crd_pkg.
`default_nettype none

interface crd_out_if;
    import crd_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] dir_x;
    logic signed [OUT_W-1:0] dir_y;
    logic signed [OUT_W-1:0] dir_z;
    logic                    zero_length;

    modport source (output valid, output dir_x, output dir_y, output dir_z,
                    output zero_length, input ready);
    modport sink   (input valid, input dir_x, input dir_y, input dir_z,
                    input zero_length, output ready);
endinterface

`default_nettype wire

FILE: src/crd_isqrt.sv
// Pipelined floor integer square root, one root bit per stage, with the
// request sideband carried alongside. Depends on crd_pkg.
`default_nettype none

module crd_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [crd_pkg::SUM_W-1:0]  radicand,
    input  crd_pkg::crd_side_t         side_in,
    output logic                       out_valid,
    output logic [crd_pkg::ROOT_W-1:0] root,
    output crd_pkg::crd_side_t         side_out
);
    import crd_pkg::*;

    logic                  valid_reg [SQRT_STEPS];
    logic [SUM_W-1:0]      x_reg     [SQRT_STEPS];
    logic [SQRT_RES_W-1:0] res_reg   [SQRT_STEPS];
    crd_side_t             side_reg  [SQRT_STEPS];

    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
        localparam int BIT_POS = 2 * (SQRT_STEPS - 1 - s);

        logic                  valid_prev;
        logic [SUM_W-1:0]      x_prev;
        logic [SQRT_RES_W-1:0] res_prev;
        crd_side_t             side_prev;
        logic [SUM_W-1:0]      x_next;
        logic [SQRT_RES_W-1:0] res_next;
        logic [SQRT_RES_W-1:0] trial;

        if (s == 0) begin : g_first
            assign valid_prev = in_valid;
            assign x_prev     = radicand;
            assign res_prev   = '0;
            assign side_prev  = side_in;
        end else begin : g_rest
            assign valid_prev = valid_reg[s-1];
            assign x_prev     = x_reg[s-1];
            assign res_prev   = res_reg[s-1];
            assign side_prev  = side_reg[s-1];
        end

        assign trial = res_prev + (SQRT_RES_W'(1) << BIT_POS);

        always_comb
        begin
            if (SQRT_RES_W'(x_prev) >= trial)
            begin
                x_next   = SUM_W'(SQRT_RES_W'(x_prev) - trial);
                res_next = (res_prev >> 1) + (SQRT_RES_W'(1) << BIT_POS);
            end
            else
            begin
                x_next   = x_prev;
                res_next = res_prev >> 1;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= valid_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s]    <= x_next;
                res_reg[s]  <= res_next;
                side_reg[s] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[SQRT_STEPS-1];
    assign root      = res_reg[SQRT_STEPS-1][ROOT_W-1:0];
    assign side_out  = side_reg[SQRT_STEPS-1];

endmodule

`default_nettype wire

FILE: src/crd_div.sv
// Pipelined restoring divider for the three lanes sharing one divisor,
// one quotient bit per stage. Depends on crd_pkg.
`default_nettype none

module crd_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [2:0][crd_pkg::NUM_W-1:0]    num,
    input  logic [crd_pkg::ROOT_W-1:0]        den,
    input  crd_pkg::crd_dside_t               side_in,
    output logic                              out_valid,
    output logic [2:0][crd_pkg::QUOT_W-1:0]   quot,
    output crd_pkg::crd_dside_t               side_out
);
    import crd_pkg::*;

    logic                   valid_reg [QUOT_W];
    logic [2:0][NUM_W-1:0]  rem_reg   [QUOT_W];
    logic [2:0][QUOT_W-1:0] quot_reg  [QUOT_W];
    logic [ROOT_W-1:0]      den_reg   [QUOT_W];
    crd_dside_t             side_reg  [QUOT_W];

    for (genvar s = 0; s < QUOT_W; s++) begin : g_step
        localparam int BIT = QUOT_W - 1 - s;

        logic                   valid_prev;
        logic [2:0][NUM_W-1:0]  rem_prev;
        logic [2:0][QUOT_W-1:0] quot_prev;
        logic [ROOT_W-1:0]      den_prev;
        crd_dside_t             side_prev;
        logic [2:0][NUM_W-1:0]  rem_next;
        logic [2:0][QUOT_W-1:0] quot_next;
        logic [DIV_W-1:0]       trial;

        if (s == 0) begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = num;
            assign quot_prev  = '0;
            assign den_prev   = den;
            assign side_prev  = side_in;
        end else begin : g_rest
            assign valid_prev = valid_reg[s-1];
            assign rem_prev   = rem_reg[s-1];
            assign quot_prev  = quot_reg[s-1];
            assign den_prev   = den_reg[s-1];
            assign side_prev  = side_reg[s-1];
        end

        assign trial = DIV_W'(den_prev) << BIT;

        always_comb
        begin
            rem_next  = rem_prev;
            quot_next = quot_prev;
            for (int k = 0; k < 3; k++)
            begin
                if (DIV_W'(rem_prev[k]) >= trial)
                begin
                    rem_next[k]       = NUM_W'(DIV_W'(rem_prev[k]) - trial);
                    quot_next[k][BIT] = 1'b1;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[s] <= 1'b0;
            else if (en)
                valid_reg[s] <= valid_prev;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= rem_next;
                quot_reg[s] <= quot_next;
                den_reg[s]  <= den_prev;
                side_reg[s] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[QUOT_W-1];
    assign quot      = quot_reg[QUOT_W-1];
    assign side_out  = side_reg[QUOT_W-1];

endmodule

`default_nettype wire

FILE: src/camera_ray_direction.sv
// Pinhole camera ray generation: screen point from three corners, minus the
// eye, scaled to a unit vector. Depends on crd_pkg, crd_in_if, crd_out_if,
// crd_isqrt and crd_div.
//
//   channel   kind             payload
//   coord     sink, request    screen_u, screen_v (unsigned Q1.15)
//   ray       source, request  dir_x, dir_y, dir_z (signed Q1.14), zero_length
//   cfg_*     write only       cfg_index, cfg_data (48-bit packed Q8.8 vector)
//
// One request per clock while the output is not stalled. The pipeline has eight
// front stages, one per root bit of the square root, one divider set-up stage,
// one per quotient bit and the output register.
// Reset clears the valid bits and the four vector registers.
// The whole pipeline advances together whenever the output register is empty
// or being taken, so a stall holds every stage in place.
`default_nettype none

module camera_ray_direction (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write_en,
    input  logic [crd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [crd_pkg::REG_W-1:0]       cfg_data,
    crd_in_if.sink                          coord,
    crd_out_if.source                       ray
);
    import crd_pkg::*;

    logic en;

    // configuration
    logic [REG_W-1:0] corner_origin_reg;
    logic [REG_W-1:0] corner_along_u_reg;
    logic [REG_W-1:0] corner_along_v_reg;
    logic [REG_W-1:0] eye_position_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            corner_origin_reg  <= '0;
            corner_along_u_reg <= '0;
            corner_along_v_reg <= '0;
            eye_position_reg   <= '0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                REG_CORNER_ORIGIN:  corner_origin_reg  <= cfg_data;
                REG_CORNER_ALONG_U: corner_along_u_reg <= cfg_data;
                REG_CORNER_ALONG_V: corner_along_v_reg <= cfg_data;
                REG_EYE_POSITION:   eye_position_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // stage A: saturate coordinates
    logic               a_valid_reg;
    logic [COORD_W-1:0] a_u_reg;
    logic [COORD_W-1:0] a_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (en)
            a_valid_reg <= coord.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_u_reg <= (coord.screen_u > COORD_ONE) ? COORD_ONE : coord.screen_u;
            a_v_reg <= (coord.screen_v > COORD_ONE) ? COORD_ONE : coord.screen_v;
        end
    end

    // stage B: per-lane products, units of 2^-23
    logic                      b_valid_reg;
    logic signed [2:0][D_W-1:0] b_pe_reg;
    logic signed [2:0][D_W-1:0] b_pu_reg;
    logic signed [2:0][D_W-1:0] b_pv_reg;
    logic signed [2:0][D_W-1:0] b_pe_next;
    logic signed [2:0][D_W-1:0] b_pu_next;
    logic signed [2:0][D_W-1:0] b_pv_next;

    always_comb
    begin
        logic signed [DELTA_W-1:0] de;
        logic signed [DELTA_W-1:0] du;
        logic signed [DELTA_W-1:0] dv;
        logic signed [PROD_W-1:0]  pu;
        logic signed [PROD_W-1:0]  pv;
        for (int k = 0; k < 3; k++)
        begin
            de = DELTA_W'(lane_of(corner_origin_reg, k)) - DELTA_W'(lane_of(eye_position_reg, k));
            du = DELTA_W'(lane_of(corner_along_u_reg, k))
               - DELTA_W'(lane_of(corner_origin_reg, k));
            dv = DELTA_W'(lane_of(corner_along_v_reg, k))
               - DELTA_W'(lane_of(corner_origin_reg, k));
            pu = $signed({1'b0, a_u_reg}) * du;
            pv = $signed({1'b0, a_v_reg}) * dv;
            b_pe_next[k] = D_W'(de) <<< COORD_FRAC;
            b_pu_next[k] = D_W'(pu);
            b_pv_next[k] = D_W'(pv);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_valid_reg <= 1'b0;
        else if (en)
            b_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_pe_reg <= b_pe_next;
            b_pu_reg <= b_pu_next;
            b_pv_reg <= b_pv_next;
        end
    end

    // stage C: direction before normalisation
    logic                       c_valid_reg;
    logic signed [2:0][D_W-1:0] c_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            c_valid_reg <= 1'b0;
        else if (en)
            c_valid_reg <= b_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                c_d_reg[k] <= b_pe_reg[k] + b_pu_reg[k] + b_pv_reg[k];
        end
    end

    // stage D: sign and magnitude
    logic                  d_valid_reg;
    logic [2:0]            d_neg_reg;
    logic [2:0][MAG_W-1:0] d_mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            d_valid_reg <= 1'b0;
        else if (en)
            d_valid_reg <= c_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                d_neg_reg[k] <= c_d_reg[k][D_W-1];
                d_mag_reg[k] <= c_d_reg[k][D_W-1] ? MAG_W'(-c_d_reg[k]) : MAG_W'(c_d_reg[k]);
            end
        end
    end

    // stage E: leading one of the largest magnitude (same as of the OR)
    logic                  e_valid_reg;
    logic [2:0]            e_neg_reg;
    logic [2:0][MAG_W-1:0] e_mag_reg;
    logic [POS_W-1:0]      e_pos_reg;
    logic                  e_zero_reg;
    logic [POS_W-1:0]      e_pos_next;
    logic [MAG_W-1:0]      mag_any;

    assign mag_any = d_mag_reg[0] | d_mag_reg[1] | d_mag_reg[2];

    always_comb
    begin
        e_pos_next = '0;
        for (int i = 0; i < MAG_W; i++)
        begin
            if (mag_any[i])
                e_pos_next = POS_W'(i);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            e_valid_reg <= 1'b0;
        else if (en)
            e_valid_reg <= d_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_neg_reg  <= d_neg_reg;
            e_mag_reg  <= d_mag_reg;
            e_pos_reg  <= e_pos_next;
            e_zero_reg <= (mag_any == '0);
        end
    end

    // stage F: block shift so the largest lies in [2^29, 2^30); right shifts truncate
    logic      f_valid_reg;
    crd_side_t f_side_reg;
    crd_side_t f_side_next;

    always_comb
    begin
        f_side_next.neg  = e_neg_reg;
        f_side_next.zero = e_zero_reg;
        for (int k = 0; k < 3; k++)
        begin
            if (e_pos_reg >= POS_W'(NORM_TOP))
                f_side_next.mag[k] = NORM_W'(e_mag_reg[k] >> (e_pos_reg - POS_W'(NORM_TOP)));
            else
                f_side_next.mag[k] = NORM_W'(e_mag_reg[k] << (POS_W'(NORM_TOP) - e_pos_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (en)
            f_valid_reg <= e_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            f_side_reg <= f_side_next;
    end

    // stage G: squares
    logic                 g_valid_reg;
    crd_side_t            g_side_reg;
    logic [2:0][SQ_W-1:0] g_sq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            g_valid_reg <= 1'b0;
        else if (en)
            g_valid_reg <= f_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_side_reg <= f_side_reg;
            for (int k = 0; k < 3; k++)
                g_sq_reg[k] <= f_side_reg.mag[k] * f_side_reg.mag[k];
        end
    end

    // stage H: sum of squares
    logic             h_valid_reg;
    crd_side_t        h_side_reg;
    logic [SUM_W-1:0] h_sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            h_valid_reg <= 1'b0;
        else if (en)
            h_valid_reg <= g_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_side_reg <= g_side_reg;
            h_sum_reg  <= SUM_W'(g_sq_reg[0]) + SUM_W'(g_sq_reg[1]) + SUM_W'(g_sq_reg[2]);
        end
    end

    // length
    logic              sq_valid;
    logic [ROOT_W-1:0] sq_root;
    crd_side_t         sq_side;

    crd_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (h_valid_reg),
        .radicand  (h_sum_reg),
        .side_in   (h_side_reg),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // divider set-up: numerator carries half the length for round half up
    logic                  p_valid_reg;
    logic [2:0][NUM_W-1:0] p_num_reg;
    logic [ROOT_W-1:0]     p_den_reg;
    crd_dside_t            p_side_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p_valid_reg <= 1'b0;
        else if (en)
            p_valid_reg <= sq_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
                p_num_reg[k] <= (NUM_W'(sq_side.mag[k]) << DIR_FRAC_BITS)
                              + NUM_W'(sq_root >> 1);
            p_den_reg       <= sq_root;
            p_side_reg.neg  <= sq_side.neg;
            p_side_reg.zero <= sq_side.zero;
        end
    end

    logic                   dv_valid;
    logic [2:0][QUOT_W-1:0] dv_quot;
    crd_dside_t             dv_side;

    crd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (p_valid_reg),
        .num       (p_num_reg),
        .den       (p_den_reg),
        .side_in   (p_side_reg),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .side_out  (dv_side)
    );

    // output register
    logic                        out_valid_reg;
    logic [2:0][OUT_W-1:0]       out_dir_reg;
    logic                        out_zero_reg;
    logic [2:0][OUT_W-1:0]       out_dir_next;

    always_comb
    begin
        logic [OUT_CALC_W-1:0] qe;
        for (int k = 0; k < 3; k++)
        begin
            qe = OUT_CALC_W'(dv_quot[k]);
            if (dv_side.neg[k])
                qe = -qe;
            out_dir_next[k] = dv_side.zero ? '0 : qe[OUT_W-1:0];
        end
    end

    assign en = !out_valid_reg || ray.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_dir_reg  <= out_dir_next;
            out_zero_reg <= dv_side.zero;
        end
    end

    assign coord.ready     = en;
    assign ray.valid       = out_valid_reg;
    assign ray.dir_x       = out_dir_reg[0];
    assign ray.dir_y       = out_dir_reg[1];
    assign ray.dir_z       = out_dir_reg[2];
    assign ray.zero_length = out_zero_reg;

endmodule

`default_nettype wire
